// ===== rtl/bvc_pkg.sv =====
// Shared types and constants of the battery voltage compensator.
`timescale 1ns / 1ps

package bvc_pkg;

    // Gain is Q4.12, so unity gain is 1 << 12.
    localparam logic [15:0] GAIN_ONE = 16'd4096;

    // Quotient bits of nominal / filtered while filtered exceeds half nominal.
    localparam int QW  = 13;
    localparam int QCW = $clog2(QW);

    // Alert codes.
    localparam logic [1:0] ALERT_NONE     = 2'd0;
    localparam logic [1:0] ALERT_LOW      = 2'd1;
    localparam logic [1:0] ALERT_CRITICAL = 2'd2;

    // Input commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_NOMINAL  = 3'd0;
    localparam logic [2:0] REG_ALPHA    = 3'd1;
    localparam logic [2:0] REG_GAIN_MIN = 3'd2;
    localparam logic [2:0] REG_GAIN_MAX = 3'd3;
    localparam logic [2:0] REG_LOW_FAC  = 3'd4;
    localparam logic [2:0] REG_CRIT_FAC = 3'd5;

    typedef struct packed {
        logic        command;
        logic [15:0] sample_millivolts;
    } t_in_item;

    typedef struct packed {
        logic [15:0] depletion_gain;
        logic [1:0]  alert_level;
        logic [15:0] filtered_millivolts;
    } t_out_item;

    typedef struct packed {
        logic [15:0] nominal_millivolts;
        logic [15:0] filter_alpha;
        logic [15:0] gain_minimum;
        logic [15:0] gain_maximum;
        logic [15:0] low_voltage_factor;
        logic [15:0] critical_voltage_factor;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic median;
        logic mult;
        logic update;
        logic check;
        logic div_step;
        logic clamp;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_reset;
        logic go_on;
        logic hot;
        logic div_last;
    } t_dp_status;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MED   = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_UPD   = 8'b0000_1000,
        ST_CHK   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_CLAMP = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/bvc_ctrl.sv =====
// Sequencer that steps the datapath through one item at a time.
`timescale 1ns / 1ps

module bvc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bvc_pkg::t_dp_status i_status,
    output bvc_pkg::t_dp_cmd    o_cmd
);

    bvc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            bvc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_status.is_reset ? bvc_pkg::ST_FIN : bvc_pkg::ST_MED;
                end
            end
            bvc_pkg::ST_MED: begin
                o_cmd.median = 1'b1;
                n_state      = i_status.go_on ? bvc_pkg::ST_MUL : bvc_pkg::ST_FIN;
            end
            bvc_pkg::ST_MUL: begin
                o_cmd.mult = 1'b1;
                n_state    = bvc_pkg::ST_UPD;
            end
            bvc_pkg::ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = bvc_pkg::ST_CHK;
            end
            bvc_pkg::ST_CHK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.hot ? bvc_pkg::ST_DIV : bvc_pkg::ST_FIN;
            end
            bvc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = bvc_pkg::ST_CLAMP;
                end
            end
            bvc_pkg::ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = bvc_pkg::ST_FIN;
            end
            bvc_pkg::ST_FIN: begin
                // Hand the item to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = bvc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bvc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == bvc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/bvc_datapath.sv =====
// Median window, low-pass filter, restoring gain divider, clamp and alert logic.
`timescale 1ns / 1ps

module bvc_datapath #(
    parameter int VOLTAGE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bvc_pkg::t_cfg       i_cfg,
    input  bvc_pkg::t_in_item   i_in_item,
    input  bvc_pkg::t_dp_cmd    i_cmd,
    output bvc_pkg::t_dp_status o_status,
    output bvc_pkg::t_out_item  o_out_item
);

    localparam int VB = VOLTAGE_BITS;
    localparam int FW = VB + 16;
    localparam int PW = FW + 16;
    localparam int RW = FW + bvc_pkg::QW;
    localparam int CW = (FW > 32) ? FW : 32;
    localparam int KW = (FW + 1 > 32) ? FW + 1 : 32;
    localparam int HW = (VB + 1 > 16) ? VB + 1 : 16;
    localparam int WW = (VB > 16) ? VB : 16;

    logic [VB-1:0]             r_win [3];
    logic                      r_filled;
    logic [FW-1:0]             r_f;
    logic                      r_seeded;
    logic                      r_crit;
    logic [1:0]                r_alert;
    logic [VB-1:0]             r_med;
    logic                      r_up;
    logic [PW-1:0]             r_prod;
    logic [31:0]               r_thr_low;
    logic [31:0]               r_thr_crit;
    logic [RW-1:0]             r_rem;
    logic [RW-1:0]             r_dvs;
    logic [bvc_pkg::QW-1:0]    r_quo;
    logic [bvc_pkg::QCW-1:0]   r_cnt;
    logic [15:0]               r_gain;
    bvc_pkg::t_out_item        r_out;

    logic [VB-1:0] sample;
    logic [VB-1:0] lo01, hi01, mid_hi, med;
    logic          med_hot;
    logic [FW-1:0] mq, diff, step;
    logic          mq_ge;
    logic          hot;
    logic          crit_now;
    logic          rem_ge;
    logic [15:0]   g0, g1, g2;
    logic [WW-1:0] whole;

    assign sample = VB'(i_in_item.sample_millivolts);

    // Middle of three: max(min(a, b), min(max(a, b), c)).
    always_comb begin
        lo01   = (r_win[0] < r_win[1]) ? r_win[0] : r_win[1];
        hi01   = (r_win[0] < r_win[1]) ? r_win[1] : r_win[0];
        mid_hi = (hi01 < r_win[2]) ? hi01 : r_win[2];
        med    = (lo01 > mid_hi) ? lo01 : mid_hi;
    end

    assign med_hot = HW'({med, 1'b0}) > HW'(i_cfg.nominal_millivolts);

    assign mq    = {r_med, 16'h0};
    assign mq_ge = mq >= r_f;
    assign diff  = mq_ge ? (mq - r_f) : (r_f - mq);
    assign step  = r_prod[PW-1:16];

    assign hot      = KW'({r_f, 1'b0}) > KW'({i_cfg.nominal_millivolts, 16'h0});
    assign crit_now = r_crit | (CW'(r_f) <= CW'(r_thr_crit));
    assign rem_ge   = r_rem >= r_dvs;

    always_comb begin
        g0 = 16'(r_quo);
        g1 = (g0 < i_cfg.gain_minimum) ? i_cfg.gain_minimum : g0;
        g2 = (g1 > i_cfg.gain_maximum) ? i_cfg.gain_maximum : g1;
    end

    assign whole = WW'(r_f[FW-1:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= 1'b0;
            r_f      <= '0;
            r_seeded <= 1'b0;
            r_crit   <= 1'b0;
            r_alert  <= bvc_pkg::ALERT_NONE;
        end else begin
            if (i_cmd.take) begin
                if (i_in_item.command == bvc_pkg::CMD_RESET) begin
                    r_filled <= 1'b0;
                    r_f      <= '0;
                    r_seeded <= 1'b0;
                    r_crit   <= 1'b0;
                    r_alert  <= bvc_pkg::ALERT_NONE;
                end else begin
                    r_filled <= 1'b1;
                end
            end
            if (i_cmd.median && !r_seeded && med_hot) begin
                // Seed: jump straight to the median.
                r_f      <= {med, 16'h0};
                r_seeded <= 1'b1;
            end
            if (i_cmd.update) begin
                r_f <= r_up ? (r_f + step) : (r_f - step);
            end
            if (i_cmd.check && hot) begin
                r_crit <= crit_now;
                if (crit_now) begin
                    r_alert <= bvc_pkg::ALERT_CRITICAL;
                end else if (CW'(r_f) <= CW'(r_thr_low)) begin
                    r_alert <= bvc_pkg::ALERT_LOW;
                end else begin
                    r_alert <= bvc_pkg::ALERT_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_gain <= bvc_pkg::GAIN_ONE;
            if (i_in_item.command == bvc_pkg::CMD_SAMPLE) begin
                // Fill the whole window on the first sample.
                r_win[0] <= sample;
                r_win[1] <= r_filled ? r_win[0] : sample;
                r_win[2] <= r_filled ? r_win[1] : sample;
            end
        end
        if (i_cmd.median) begin
            r_med <= med;
        end
        if (i_cmd.mult) begin
            r_up       <= mq_ge;
            r_prod     <= PW'(i_cfg.filter_alpha) * PW'(diff);
            r_thr_low  <= 32'(i_cfg.nominal_millivolts) * 32'(i_cfg.low_voltage_factor);
            r_thr_crit <= 32'(i_cfg.nominal_millivolts) * 32'(i_cfg.critical_voltage_factor);
        end
        if (i_cmd.check) begin
            r_rem <= RW'({i_cfg.nominal_millivolts, 28'h0});
            r_dvs <= RW'(r_f) << (bvc_pkg::QW - 1);
            r_quo <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[bvc_pkg::QW-2:0], rem_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.clamp) begin
            r_gain <= g2;
        end
        if (i_cmd.load_out) begin
            r_out.depletion_gain      <= r_gain;
            r_out.alert_level         <= r_alert;
            r_out.filtered_millivolts <= (whole > WW'(16'hFFFF)) ? 16'hFFFF : whole[15:0];
        end
    end

    always_comb begin
        o_status.is_reset = (i_in_item.command == bvc_pkg::CMD_RESET);
        o_status.go_on    = r_seeded | med_hot;
        o_status.hot      = hot;
        o_status.div_last = (r_cnt == bvc_pkg::QCW'(bvc_pkg::QW - 1));
    end

    assign o_out_item = r_out;

endmodule

// ===== rtl/battery_voltage_compensator_core.sv =====
// A reset item goes from accept straight to the finish state; a sample item steps through median,
// multiply, update, check, the restoring divider for nominal / filtered, and clamp. A sample
// that does not seed or stays at or below half nominal skips the divider and the clamp.
// Throughput: one item at a time; the output register lets the next item start while
// a result waits. Reset clears filter state and loads the register defaults.
`timescale 1ns / 1ps

module battery_voltage_compensator_core #(
    parameter int VOLTAGE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bvc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bvc_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    bvc_pkg::t_cfg       r_cfg;
    bvc_pkg::t_dp_cmd    cmd;
    bvc_pkg::t_dp_status status;
    logic [2:0]          reg_idx;
    logic [15:0]         rd_val;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nominal_millivolts      <= 16'd11100;
            r_cfg.filter_alpha            <= 16'd655;
            r_cfg.gain_minimum            <= 16'd4096;
            r_cfg.gain_maximum            <= 16'd6144;
            r_cfg.low_voltage_factor      <= 16'd58982;
            r_cfg.critical_voltage_factor <= 16'd55705;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                bvc_pkg::REG_NOMINAL:  r_cfg.nominal_millivolts      <= pwdata[15:0];
                bvc_pkg::REG_ALPHA:    r_cfg.filter_alpha            <= pwdata[15:0];
                bvc_pkg::REG_GAIN_MIN: r_cfg.gain_minimum            <= pwdata[15:0];
                bvc_pkg::REG_GAIN_MAX: r_cfg.gain_maximum            <= pwdata[15:0];
                bvc_pkg::REG_LOW_FAC:  r_cfg.low_voltage_factor      <= pwdata[15:0];
                bvc_pkg::REG_CRIT_FAC: r_cfg.critical_voltage_factor <= pwdata[15:0];
                default: begin
                    // Drop writes outside the register map.
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bvc_pkg::REG_NOMINAL:  rd_val = r_cfg.nominal_millivolts;
            bvc_pkg::REG_ALPHA:    rd_val = r_cfg.filter_alpha;
            bvc_pkg::REG_GAIN_MIN: rd_val = r_cfg.gain_minimum;
            bvc_pkg::REG_GAIN_MAX: rd_val = r_cfg.gain_maximum;
            bvc_pkg::REG_LOW_FAC:  rd_val = r_cfg.low_voltage_factor;
            bvc_pkg::REG_CRIT_FAC: rd_val = r_cfg.critical_voltage_factor;
            default:               rd_val = 16'h0;
        endcase
    end

    assign prdata = {16'h0, rd_val};

    bvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bvc_datapath #(
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

// ===== tb/bvc_result_monitor.sv =====
// Result monitor for the battery voltage compensator: tracks filter state and checks every item.
`timescale 1ns / 1ps

module bvc_result_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  bvc_pkg::t_in_item           i_in_item,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  bvc_pkg::t_out_item          i_out_item,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [4:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    localparam bvc_pkg::t_cfg RESET_REGS = {16'd11100, 16'd655, 16'd4096, 16'd6144,
                                            16'd58982, 16'd55705};

    bvc_pkg::t_cfg      regs;
    logic [15:0]        win [3];
    logic               win_full;
    logic [31:0]        filt_q16;
    logic               seeded;
    logic               crit_hold;
    logic [1:0]         alert_now;

    bvc_pkg::t_out_item results_due [$];
    bvc_pkg::t_out_item want;
    int                 fails = 0;
    int                 checked = 0;

    // Advance the median window and low-pass filter by one item; return its result.
    function automatic bvc_pkg::t_out_item advance_filter(input bvc_pkg::t_in_item it);
        logic [15:0] s;
        logic [15:0] med;
        logic [31:0] mq;
        logic [63:0] step;
        logic [63:0] gain;
        if (it.command == bvc_pkg::CMD_RESET) begin
            win_full  = 1'b0;
            filt_q16  = '0;
            seeded    = 1'b0;
            crit_hold = 1'b0;
            alert_now = bvc_pkg::ALERT_NONE;
            return {bvc_pkg::GAIN_ONE, bvc_pkg::ALERT_NONE, 16'd0};
        end
        s = it.sample_millivolts;
        if (!win_full) begin
            win[0] = s;
            win[1] = s;
            win[2] = s;
            win_full = 1'b1;
        end
        win[2] = win[1];
        win[1] = win[0];
        win[0] = s;
        if (win[0] > win[1])
            med = (win[1] > win[2]) ? win[1] : ((win[0] > win[2]) ? win[2] : win[0]);
        else
            med = (win[0] > win[2]) ? win[0] : ((win[1] > win[2]) ? win[2] : win[1]);
        mq = {med, 16'h0000};

        if (!seeded) begin
            if ({med, 1'b0} > {1'b0, regs.nominal_millivolts}) begin
                filt_q16 = mq;
                seeded = 1'b1;
            end else begin
                return {bvc_pkg::GAIN_ONE, alert_now, filt_q16[31:16]};
            end
        end

        // Step truncates toward zero on the magnitude, then takes the sign of the error.
        if (mq >= filt_q16) begin
            step = (64'(regs.filter_alpha) * 64'(mq - filt_q16)) >> 16;
            filt_q16 = filt_q16 + step[31:0];
        end else begin
            step = (64'(regs.filter_alpha) * 64'(filt_q16 - mq)) >> 16;
            filt_q16 = filt_q16 - step[31:0];
        end

        gain = 64'(bvc_pkg::GAIN_ONE);
        if ({filt_q16, 1'b0} > {1'b0, regs.nominal_millivolts, 16'h0000}) begin
            gain = (64'(regs.nominal_millivolts) << 28) / 64'(filt_q16);
            // Raise to the minimum first, so a crossed maximum wins.
            if (gain < 64'(regs.gain_minimum)) gain = 64'(regs.gain_minimum);
            if (gain > 64'(regs.gain_maximum)) gain = 64'(regs.gain_maximum);
            if (64'(filt_q16) <= 64'(regs.nominal_millivolts) *
                                 64'(regs.critical_voltage_factor))
                crit_hold = 1'b1;
            if (crit_hold)
                alert_now = bvc_pkg::ALERT_CRITICAL;
            else if (64'(filt_q16) <= 64'(regs.nominal_millivolts) *
                                      64'(regs.low_voltage_factor))
                alert_now = bvc_pkg::ALERT_LOW;
            else
                alert_now = bvc_pkg::ALERT_NONE;
        end
        return {gain[15:0], alert_now, filt_q16[31:16]};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs      = RESET_REGS;
            win_full  = 1'b0;
            filt_q16  = '0;
            seeded    = 1'b0;
            crit_hold = 1'b0;
            alert_now = bvc_pkg::ALERT_NONE;
            results_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    bvc_pkg::REG_NOMINAL:  regs.nominal_millivolts      = i_pwdata[15:0];
                    bvc_pkg::REG_ALPHA:    regs.filter_alpha            = i_pwdata[15:0];
                    bvc_pkg::REG_GAIN_MIN: regs.gain_minimum            = i_pwdata[15:0];
                    bvc_pkg::REG_GAIN_MAX: regs.gain_maximum            = i_pwdata[15:0];
                    bvc_pkg::REG_LOW_FAC:  regs.low_voltage_factor      = i_pwdata[15:0];
                    bvc_pkg::REG_CRIT_FAC: regs.critical_voltage_factor = i_pwdata[15:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready)
                results_due.push_back(advance_filter(i_in_item));

            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got gain %0d alert %0d %s %0d",
                             $time, i_out_item.depletion_gain, i_out_item.alert_level,
                             "filtered", i_out_item.filtered_millivolts);
                end else begin
                    want = results_due.pop_front();
                    checked++;
                    if (i_out_item.depletion_gain !== want.depletion_gain) begin
                        fails++;
                        $display("%0t: depletion_gain expected %0d, got %0d",
                                 $time, want.depletion_gain, i_out_item.depletion_gain);
                    end
                    if (i_out_item.alert_level !== want.alert_level) begin
                        fails++;
                        $display("%0t: alert_level expected %0d, got %0d",
                                 $time, want.alert_level, i_out_item.alert_level);
                    end
                    if (i_out_item.filtered_millivolts !== want.filtered_millivolts) begin
                        fails++;
                        $display("%0t: filtered_millivolts expected %0d, got %0d",
                                 $time, want.filtered_millivolts, i_out_item.filtered_millivolts);
                    end
                end
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== tb/battery_voltage_compensator_core_test.sv =====
// Stimulus and verdict for the battery voltage compensator core.
`timescale 1ns / 1ps

module battery_voltage_compensator_core_test;

    localparam int LONG_HOLD = 300;

    // Register settings: {nominal, alpha, gain min, gain max, low factor, critical factor}.
    localparam bvc_pkg::t_cfg CFG_DIRECTED     = {16'd11100, 16'd65535, 16'd4096, 16'd6144,
                                                  16'd58982, 16'd55705};
    localparam bvc_pkg::t_cfg CFG_FLOOR        = {16'd0, 16'd65535, 16'd0, 16'd65535,
                                                  16'd0, 16'd0};
    localparam bvc_pkg::t_cfg CFG_CEILING      = {16'd65535, 16'd0, 16'd65535, 16'd0,
                                                  16'd65535, 16'd65535};
    localparam bvc_pkg::t_cfg CFG_RESET_VALUES = {16'd11100, 16'd655, 16'd4096, 16'd6144,
                                                  16'd58982, 16'd55705};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    bvc_pkg::t_in_item  i_in_item = '0;
    logic               i_out_ready = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    bvc_pkg::t_out_item o_out_item;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int results_pending;
    int results_checked;

    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    bit            hold_pending = 1'b0;
    int            holds_done = 0;
    int            items_sent = 0;
    int            resets_sent = 0;
    int            settings_used = 0;
    int            level_mv = 0;
    bvc_pkg::t_cfg cfg_now = CFG_RESET_VALUES;

    // Walk from seeding, through low and critical, back above half nominal.
    bvc_pkg::t_in_item directed_seq [23] = '{
        {bvc_pkg::CMD_RESET, 16'hFFFF},   {bvc_pkg::CMD_SAMPLE, 16'd0},
        {bvc_pkg::CMD_SAMPLE, 16'd5550},  {bvc_pkg::CMD_SAMPLE, 16'd5550},
        {bvc_pkg::CMD_SAMPLE, 16'd5551},  {bvc_pkg::CMD_SAMPLE, 16'd5551},
        {bvc_pkg::CMD_RESET, 16'h0000},   {bvc_pkg::CMD_SAMPLE, 16'd12000},
        {bvc_pkg::CMD_SAMPLE, 16'd65535}, {bvc_pkg::CMD_SAMPLE, 16'd10000},
        {bvc_pkg::CMD_SAMPLE, 16'd10000}, {bvc_pkg::CMD_SAMPLE, 16'd9900},
        {bvc_pkg::CMD_SAMPLE, 16'd9900},  {bvc_pkg::CMD_SAMPLE, 16'd9000},
        {bvc_pkg::CMD_SAMPLE, 16'd9000},  {bvc_pkg::CMD_SAMPLE, 16'd11500},
        {bvc_pkg::CMD_SAMPLE, 16'd11500}, {bvc_pkg::CMD_SAMPLE, 16'd5000},
        {bvc_pkg::CMD_SAMPLE, 16'd5000},  {bvc_pkg::CMD_SAMPLE, 16'd65535},
        {bvc_pkg::CMD_SAMPLE, 16'd65535}, {bvc_pkg::CMD_RESET, 16'h1234},
        {bvc_pkg::CMD_SAMPLE, 16'hFFFF}
    };

    battery_voltage_compensator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bvc_result_monitor monitor_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending),
        .o_checked    (results_checked)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("battery_voltage_compensator_core verification failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                holds_done++;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic offer_item(input bvc_pkg::t_in_item it);
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (it.command == bvc_pkg::CMD_RESET) resets_sent++;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid and hold until every accepted item has its result.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input bvc_pkg::t_cfg c);
        wait_results_drained();
        reg_write(bvc_pkg::REG_NOMINAL, c.nominal_millivolts);
        reg_write(bvc_pkg::REG_ALPHA, c.filter_alpha);
        reg_write(bvc_pkg::REG_GAIN_MIN, c.gain_minimum);
        reg_write(bvc_pkg::REG_GAIN_MAX, c.gain_maximum);
        reg_write(bvc_pkg::REG_LOW_FAC, c.low_voltage_factor);
        reg_write(bvc_pkg::REG_CRIT_FAC, c.critical_voltage_factor);
        cfg_now  = c;
        level_mv = c.nominal_millivolts;
        settings_used++;
    endtask

    function automatic bvc_pkg::t_cfg random_settings();
        bvc_pkg::t_cfg c;
        c.nominal_millivolts      = 16'($urandom_range(2000, 40000));
        c.filter_alpha            = $urandom_range(1) ? 16'($urandom_range(200, 4000))
                                                      : 16'($urandom_range(4000, 65535));
        c.gain_minimum            = 16'($urandom_range(0, 5000));
        c.gain_maximum            = 16'($urandom_range(3000, 9000));
        c.low_voltage_factor      = 16'($urandom_range(50000, 65535));
        c.critical_voltage_factor = 16'($urandom_range(40000, 60000));
        return c;
    endfunction

    // Mostly a drifting voltage around nominal; some jumps, spikes, noise and resets.
    function automatic bvc_pkg::t_in_item next_sample_item();
        int r;
        int nom_ref;
        int span;
        r = $urandom_range(99);
        nom_ref = (cfg_now.nominal_millivolts < 64) ? 1000 : int'(cfg_now.nominal_millivolts);
        if (r < 3) return {bvc_pkg::CMD_RESET, 16'($urandom)};
        if (r < 11) return {bvc_pkg::CMD_SAMPLE, 16'($urandom)};
        if (r < 13) return {bvc_pkg::CMD_SAMPLE, 16'h0000};
        if (r < 15) return {bvc_pkg::CMD_SAMPLE, 16'hFFFF};
        if (r < 20) begin
            level_mv = nom_ref * $urandom_range(30, 125) / 100;
        end else begin
            span = nom_ref / 25 + 2;
            level_mv = level_mv + int'($urandom_range(0, span)) - span / 2;
        end
        if (level_mv < 0) level_mv = 0;
        if (level_mv > 65535) level_mv = 65535;
        return {bvc_pkg::CMD_SAMPLE, 16'(level_mv)};
    endfunction

    task automatic run_random(input int count, input int hold_at, input int pause_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) hold_pending = 1'b1;
            if (k == pause_at) wait_results_drained();
            offer_item(next_sample_item());
        end
    endtask

    initial begin
        int drain_cycles;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 63;
        program_regs(CFG_DIRECTED);
        foreach (directed_seq[k]) offer_item(directed_seq[k]);
        program_regs(CFG_FLOOR);
        run_random(80, -1, -1);
        program_regs(random_settings());
        run_random(220, 40, -1);

        tx_idle_pct = 63;
        rx_idle_pct = 8;
        program_regs(CFG_CEILING);
        run_random(80, -1, -1);
        program_regs(random_settings());
        run_random(250, -1, -1);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(CFG_RESET_VALUES);
        run_random(120, -1, 60);
        program_regs(random_settings());
        run_random(250, 30, 150);

        i_in_valid <= 1'b0;
        drain_cycles = 0;
        while (results_pending != 0 && drain_cycles < 100000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (results_pending != 0) begin
            $display("battery_voltage_compensator_core verification failed");
        end else begin
            repeat (40) @(posedge i_clk);
            $display("Run covered %0d items (%0d state resets) under %0d register settings,",
                     items_sent, resets_sent, settings_used);
            $display("three idle profiles and %0d long output hold-offs; %0d results compared.",
                     holds_done, results_checked);
            if (fail_count == 0)
                $display("battery_voltage_compensator_core verification clean");
            else
                $display("battery_voltage_compensator_core verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bvc_pkg.sv
rtl/bvc_ctrl.sv
rtl/bvc_datapath.sv
rtl/battery_voltage_compensator_core.sv
tb/bvc_result_monitor.sv
tb/battery_voltage_compensator_core_test.sv
